/* rtl/core/ccnl_pkg.sv */
// ----------------------------------------------------------------------------
// ccnl_pkg: shared types and constants for the cell neighbor lookup
// Subdetector codes, request kinds, register indexes and config struct.
// ----------------------------------------------------------------------------
package ccnl_pkg;

  localparam int unsigned PhiBinsDefault = 72;

  typedef enum logic [1:0] {
    SD_BARREL  = 2'd0,
    SD_ENDCAP  = 2'd1,
    SD_OUTER   = 2'd2,
    SD_FORWARD = 2'd3
  } subdet_e;

  typedef enum logic [2:0] {
    K_VALID   = 3'd0,
    K_PHI_UP  = 3'd1,
    K_PHI_DN  = 3'd2,
    K_ETA_E   = 3'd3,
    K_ETA_W   = 3'd4,
    K_DEEPER  = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_MASK   = 2'd1,
    REG_HB_LIM = 2'd2,
    REG_HE_LIM = 2'd3
  } reg_e;

  typedef struct packed {
    logic [1:0] mode;      // effective mode, 3 folded to 0
    logic [3:0] mask;
    logic [2:0] hb_lim;
    logic [2:0] he_lim;
  } cfg_t;

endpackage

/* rtl/core/ccnl_cfg_regs.sv */
// ----------------------------------------------------------------------------
// ccnl_cfg_regs: configuration register file
// Holds geometry mode, subdetector mask and the upgrade depth limits.
// ----------------------------------------------------------------------------
module ccnl_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  output ccnl_pkg::cfg_t      cfg_o
);
  import ccnl_pkg::*;

  logic [1:0] mode_q;
  logic [3:0] mask_q;
  logic [2:0] hb_q, he_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 2'd0;
      mask_q <= 4'd0;
      hb_q   <= 3'd7;
      he_q   <= 3'd7;
    end else if (cfg_valid_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_MODE:   mode_q <= cfg_data_i[1:0];
        REG_MASK:   mask_q <= cfg_data_i[3:0];
        REG_HB_LIM: hb_q   <= cfg_data_i[2:0];
        REG_HE_LIM: he_q   <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.mode   = (mode_q == 2'd3) ? 2'd0 : mode_q;
  assign cfg_o.mask   = mask_q;
  assign cfg_o.hb_lim = hb_q;
  assign cfg_o.he_lim = he_q;

endmodule

/* rtl/core/ccnl_valid_chk.sv */
// ----------------------------------------------------------------------------
// ccnl_valid_chk: cell validity rules
// Ring and depth rules per subdetector and mode, optional mask.
// ----------------------------------------------------------------------------
module ccnl_valid_chk #(
  parameter int unsigned PHI_BINS = ccnl_pkg::PhiBinsDefault
) (
  input  ccnl_pkg::cfg_t cfg_i,
  input  logic           use_mask_i,
  input  logic [1:0]     sd_i,
  input  logic [5:0]     a_i,      // ring magnitude
  input  logic [7:0]     iphi_i,   // may be out of range
  input  logic [2:0]     depth_i,
  output logic           ok_o
);
  import ccnl_pkg::*;

  localparam logic [7:0] PhiMax = 8'(PHI_BINS);

  logic [5:0] dbl, trp;
  logic       base, rule, even_bad, m2;
  logic [7:0] p1;

  always_comb begin
    m2   = (cfg_i.mode == 2'd2);
    dbl  = (cfg_i.mode != 2'd0) ? 6'd22 : 6'd21;
    trp  = (cfg_i.mode != 2'd0) ? 6'd24 : 6'd27;
    p1   = iphi_i + 8'd1;
    base = (a_i != 6'd0) && (iphi_i != 8'd0) && (iphi_i <= PhiMax) && (a_i <= 6'd41);
    even_bad = (a_i >= dbl) && !iphi_i[0];
    case (subdet_e'(sd_i))
      SD_BARREL:
        if (m2) rule = !(a_i > 6'd16 || depth_i > cfg_i.hb_lim ||
                         (a_i == 6'd16 && depth_i > 3'd2));
        else    rule = !(a_i > 6'd16 || depth_i > 3'd2 ||
                         (a_i <= 6'd14 && depth_i > 3'd1));
      SD_ENDCAP:
        if (m2) rule = !(depth_i > cfg_i.he_lim || a_i < 6'd16 || a_i > 6'd29 ||
                         (a_i == 6'd16 && depth_i < 3'd3) || even_bad);
        else    rule = !(depth_i > 3'd3 || a_i < 6'd16 || a_i > 6'd29 ||
                         (a_i == 6'd16 && depth_i != 3'd3) ||
                         (a_i == 6'd17 && depth_i != 3'd1 && cfg_i.mode != 2'd1) ||
                         (((a_i >= 6'd17 && a_i < trp) || a_i == 6'd29) &&
                          depth_i > 3'd2) || even_bad);
      SD_OUTER: rule = !(a_i > 6'd15 || depth_i != 3'd4);
      default:  rule = !(a_i < 6'd29 || !iphi_i[0] || depth_i > 3'd2 ||
                         (a_i >= 6'd40 && p1[1:0] != 2'd0));
    endcase
    ok_o = base && rule && !(use_mask_i && cfg_i.mask[sd_i]);
  end

endmodule

/* rtl/core/ccnl_nb_logic.sv */
// ----------------------------------------------------------------------------
// ccnl_nb_logic: neighbor computation
// Combinational answer for one registered request.
// ----------------------------------------------------------------------------
module ccnl_nb_logic #(
  parameter int unsigned PHI_BINS = ccnl_pkg::PhiBinsDefault
) (
  input  ccnl_pkg::cfg_t    cfg_i,
  input  logic [2:0]        kind_i,
  input  logic [1:0]        sd_i,
  input  logic signed [6:0] ieta_i,
  input  logic [6:0]        iphi_i,
  input  logic [2:0]        depth_i,
  output logic              found_o,
  output logic [1:0]        count_o,
  output logic [1:0]        nsd_o,
  output logic signed [6:0] neta_o,
  output logic [6:0]        nphi_o,
  output logic [2:0]        ndep_o,
  output logic [6:0]        sphi_o
);
  import ccnl_pkg::*;

  localparam logic [7:0] PhiMax = 8'(PHI_BINS);
  localparam logic [7:0] PhiM1  = 8'(PHI_BINS - 1);

  // ring magnitudes are 7 bits so that -64 and its outward step stay distinct
  logic [6:0] a, dbl, trp;
  logic       neg, nneg, up;
  logic [7:0] ph;
  // checker A: source cell / eta candidate 1 / deeper; checker B: candidate 2
  logic       ua, oka, okb;
  logic [1:0] sda;
  logic [5:0] aa;
  logic [7:0] pa, pb;
  logic [2:0] da;
  logic       outward;
  logic [1:0] nsd;
  logic [6:0] na;
  logic [7:0] nphi, sphi;
  logic [3:0] ndep, nbins;
  logic       two, ok;
  logic [1:0] cnt;
  logic       fnd;

  ccnl_valid_chk #(.PHI_BINS(PHI_BINS)) u_chk_a (
    .cfg_i, .use_mask_i(ua), .sd_i(sda), .a_i(aa), .iphi_i(pa),
    .depth_i(da), .ok_o(oka));
  ccnl_valid_chk #(.PHI_BINS(PHI_BINS)) u_chk_b (
    .cfg_i, .use_mask_i(1'b1), .sd_i(sda), .a_i(aa), .iphi_i(pb),
    .depth_i(da), .ok_o(okb));

  always_comb begin
    // ring 0 counts as the negative side
    neg = ieta_i[6] || (ieta_i == 7'sd0);
    a   = ieta_i[6] ? 7'(-ieta_i) : {1'b0, ieta_i[5:0]};
    ph  = {1'b0, iphi_i};
    dbl = (cfg_i.mode != 2'd0) ? 7'd22 : 7'd21;
    trp = (cfg_i.mode != 2'd0) ? 7'd24 : 7'd27;
    up  = (kind_i == K_PHI_UP);
    outward = (kind_i == K_ETA_W) == !neg;
    ua = 1'b1; sda = sd_i; aa = a[6] ? 6'd63 : a[5:0]; pa = ph; pb = 8'd0;
    da = depth_i;
    nsd = sd_i; na = a; nneg = neg; nphi = ph; sphi = 8'd0; ndep = {1'b0, depth_i};
    two = 1'b0; ok = 1'b1; nbins = 4'd0;
    cnt = 2'd0; fnd = 1'b0;
    case (kind_i)
      K_VALID: fnd = oka;
      K_PHI_UP, K_PHI_DN: begin
        if (sd_i == SD_ENDCAP && a >= dbl || sd_i == SD_FORWARD && a < 7'd40)
          nphi = up ? ((ph == PhiM1) ? 8'd1 : ph + 8'd2)
                    : ((ph == 8'd1) ? PhiM1 : ph - 8'd2);
        else if (sd_i == SD_FORWARD)
          nphi = up ? ((ph == PhiM1) ? 8'd3 : ph + 8'd4)
                    : ((ph == 8'd3) ? PhiM1 : ph - 8'd4);
        else
          nphi = up ? ((ph == PhiMax) ? 8'd1 : ph + 8'd1)
                    : ((ph == 8'd1) ? PhiMax : ph - 8'd1);
        cnt = {1'b0, oka};
      end
      K_ETA_E, K_ETA_W: begin
        if (outward) begin
          na = a + 7'd1;
          if (a == dbl - 7'd1 && !ph[0]) nphi = ph - 8'd1;
          else if (a == 7'd39 && (ph[1:0] + 2'd1) != 2'd0)
            nphi = (ph == 8'd1) ? PhiM1 : ph - 8'd2;
          else if (a == 7'd16) begin nsd = SD_ENDCAP; ndep = 4'd1; end
          else if (a == 7'd29) begin nsd = SD_FORWARD; ndep = 4'd1; end
          sda = nsd; aa = na[6] ? 6'd63 : na[5:0]; pa = nphi; da = ndep[2:0];
          cnt = {1'b0, oka};
        end else begin
          na = a - 7'd1;
          if (a == dbl) begin two = 1'b1; sphi = ph + 8'd1; end
          else if (a == 7'd40) begin
            two = 1'b1; sphi = (ph == PhiM1) ? 8'd1 : ph + 8'd2;
          end else if (a <= 7'd1) begin na = 7'd1; nneg = !neg; end
          else if (a == 7'd17) nsd = SD_BARREL;
          else if (a == 7'd30) nsd = SD_ENDCAP;
          sda = nsd; aa = na[6] ? 6'd63 : na[5:0]; pa = ph; pb = sphi; da = ndep[2:0];
          if (oka && two && okb) cnt = 2'd2;
          else if (oka) begin cnt = 2'd1; sphi = 8'd0; end
          else if (two && okb) begin cnt = 2'd1; nphi = sphi; sphi = 8'd0; end
        end
      end
      K_DEEPER: begin
        ua = 1'b0;
        case (subdet_e'(sd_i))
          SD_BARREL:
            if (cfg_i.mode == 2'd2) nbins = (a == 7'd16) ? 4'd2 : {1'b0, cfg_i.hb_lim};
            else nbins = (a <= 7'd14) ? 4'd1 : 4'd2;
          SD_ENDCAP:
            if (cfg_i.mode == 2'd2)
              nbins = (a == 7'd16) ? {1'b0, cfg_i.he_lim} - 4'd2 : {1'b0, cfg_i.he_lim};
            else if (a == 7'd16 || a == 7'd17) nbins = 4'd1;
            else if (a == 7'd29) nbins = 4'd2;
            else nbins = (a >= trp) ? 4'd3 : 4'd2;
          SD_FORWARD: nbins = 4'd2;
          default:    nbins = 4'd1;
        endcase
        ndep = {1'b0, depth_i} + 4'd1;
        // nbins may go negative in upgrade mode; ndep is never negative
        if ($signed({1'b0, ndep}) > $signed({nbins[3], nbins})) begin
          if (sd_i == SD_BARREL && a < 7'd15) begin nsd = SD_OUTER; ndep = 4'd4; end
          else if (sd_i == SD_BARREL && a == 7'd16) nsd = SD_ENDCAP;
          else if (sd_i == SD_ENDCAP && a == 7'd28) begin
            nsd = SD_FORWARD; na = 7'd29; ndep = 4'd1;
          end else if (sd_i == SD_ENDCAP && a == 7'd29) na = 7'd28;
          else ok = 1'b0;
        end
        sda = nsd; aa = na[6] ? 6'd63 : na[5:0]; pa = ph; da = ndep[2:0];
        cnt = {1'b0, ok && !ndep[3] && oka};
      end
      default: ;
    endcase
    if (kind_i != K_VALID && cnt != 2'd0) fnd = 1'b1;
    found_o = fnd;
    count_o = cnt;
    if (cnt == 2'd0) begin
      nsd_o = 2'd0; neta_o = 7'sd0; nphi_o = 7'd0; ndep_o = 3'd0; sphi_o = 7'd0;
    end else begin
      nsd_o  = nsd;
      neta_o = nneg ? 7'(-$signed({1'b0, na})) : $signed(na);
      nphi_o = nphi[6:0];
      ndep_o = ndep[2:0];
      sphi_o = (cnt == 2'd2) ? sphi[6:0] : 7'd0;
    end
  end

endmodule

/* rtl/core/calorimeter_cell_neighbor_lookup_unit.sv */
// ----------------------------------------------------------------------------
// calorimeter_cell_neighbor_lookup_unit: calorimeter cell neighbor lookup
// Validity check or neighbor search for one cell address per clock while out_ready_i is high.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one request item: kind and
//   cell address. Output channel (out_valid_o/out_ready_i) returns one result
//   item per request. Config channel (cfg_valid_i/cfg_ready_o) writes one of
//   four registers by index; always ready, write only while idle.
// Datapath: the request is held in the input register, passes the lookup logic
//   and is captured in the result register, which drives the outputs.
// Throughput: one item per clock while out_ready_i is high; the lookup is a
//   single combinational pass between the two registers.
// Stall: when out_ready_i is low the result register holds, and the input
//   register keeps one item; in_ready_o drops only when both are full.
// Reset: both stages empty, mode and mask 0, depth limits 7.
// ----------------------------------------------------------------------------
module calorimeter_cell_neighbor_lookup_unit #(
  parameter int unsigned PHI_BINS = ccnl_pkg::PhiBinsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        kind_i,
  input  logic [1:0]        cell_subdet_i,
  input  logic signed [6:0] cell_ieta_i,
  input  logic [6:0]        cell_iphi_i,
  input  logic [2:0]        cell_depth_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              found_o,
  output logic [1:0]        neighbor_count_o,
  output logic [1:0]        nb_subdet_o,
  output logic signed [6:0] nb_ieta_o,
  output logic [6:0]        nb_iphi_o,
  output logic [2:0]        nb_depth_o,
  output logic [6:0]        second_iphi_o
);
  import ccnl_pkg::*;

  cfg_t cfg;

  logic              s1_v_q;
  logic [2:0]        kind_q;
  logic [1:0]        sd_q;
  logic signed [6:0] eta_q;
  logic [6:0]        phi_q;
  logic [2:0]        dep_q;
  logic              s2_v_q;
  logic              s1_adv, s2_load;

  logic              f_d;
  logic [1:0]        c_d, nsd_d, c_q, nsd_q;
  logic signed [6:0] neta_d, neta_q;
  logic [6:0]        nphi_d, sphi_d, nphi_q, sphi_q;
  logic [2:0]        ndep_d, ndep_q;
  logic              f_q;

  ccnl_cfg_regs u_cfg (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .cfg_o(cfg));

  ccnl_nb_logic #(.PHI_BINS(PHI_BINS)) u_nb (
    .cfg_i(cfg), .kind_i(kind_q), .sd_i(sd_q), .ieta_i(eta_q), .iphi_i(phi_q),
    .depth_i(dep_q), .found_o(f_d), .count_o(c_d), .nsd_o(nsd_d),
    .neta_o(neta_d), .nphi_o(nphi_d), .ndep_o(ndep_d), .sphi_o(sphi_d));

  assign s2_load    = s1_v_q && (!s2_v_q || out_ready_i);
  assign s1_adv     = !s1_v_q || s2_load;
  assign in_ready_o = s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_adv) s1_v_q <= in_valid_i;
      if (s2_load) s2_v_q <= 1'b1;
      else if (out_ready_i) s2_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && in_valid_i) begin
      kind_q <= kind_i; sd_q <= cell_subdet_i; eta_q <= cell_ieta_i;
      phi_q <= cell_iphi_i; dep_q <= cell_depth_i;
    end
    if (s2_load) begin
      f_q <= f_d; c_q <= c_d; nsd_q <= nsd_d; neta_q <= neta_d;
      nphi_q <= nphi_d; ndep_q <= ndep_d; sphi_q <= sphi_d;
    end
  end

  assign out_valid_o      = s2_v_q;
  assign found_o          = f_q;
  assign neighbor_count_o = c_q;
  assign nb_subdet_o      = nsd_q;
  assign nb_ieta_o        = neta_q;
  assign nb_iphi_o        = nphi_q;
  assign nb_depth_o       = ndep_q;
  assign second_iphi_o    = sphi_q;

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && s2_v_q && !out_ready_i |-> !in_ready_o) else $error("accept while full");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(nb_iphi_o))
    else $error("result lost under stall");
  a_count_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && neighbor_count_o != 2'd0 |-> found_o) else $error("count without found");

endmodule
